FILE: rtl/grid_line_overlay_defines.svh
// ----------------------------------------------------------------------------
// grid_line_overlay_defines
// assertion macros shared by the grid overlay checker
// ----------------------------------------------------------------------------
`ifndef GRID_LINE_OVERLAY_DEFINES_SVH
`define GRID_LINE_OVERLAY_DEFINES_SVH

// consequent in the cycle after the antecedent, quiet during reset
`define GLO_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// consequent in the same cycle as the antecedent, quiet during reset
`define GLO_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent in the cycle after the antecedent, also checked across reset
`define GLO_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/glo_pkg.sv
// ----------------------------------------------------------------------------
// glo_pkg
// types and constants of the grid line overlay
// ----------------------------------------------------------------------------
`default_nettype none

package glo_pkg;

    localparam int COLOR_W = 8;
    localparam int PARTS_W = 5;
    localparam int THICK_W = 13;
    localparam int DIM_W   = 13;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;
    localparam int PIX_W   = 3 * COLOR_W;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COLUMN_PARTS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_PARTS      = 3'd1;
    localparam logic [IDX_W-1:0] REG_LINE_THICKNESS = 3'd2;
    localparam logic [IDX_W-1:0] REG_LINE_RED       = 3'd3;
    localparam logic [IDX_W-1:0] REG_LINE_GREEN     = 3'd4;
    localparam logic [IDX_W-1:0] REG_LINE_BLUE      = 3'd5;
    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH    = 3'd6;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT   = 3'd7;

    typedef enum logic [3:0] {
        S_LOAD = 4'b0001,
        S_DIV  = 4'b0010,
        S_SEEK = 4'b0100,
        S_RUN  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/grid_line_overlay.sv
// ----------------------------------------------------------------------------
// grid_line_overlay
// draws a column_parts by row_parts grid over a raster-order rgb pixel stream
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one pixel per clock unless the output
// stalls or the spacings are being rebuilt, with one output register between
// the two sides. Line positions are never searched per pixel: a walker per
// direction holds the next line not yet passed, stepping at most one line per
// pixel or row. After reset and after every configuration write the input
// stalls while the spacings are rebuilt: a load state, the bit-serial restoring
// divider and a seek state stepping the walkers to the current pixel position.
// Write configuration only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_line_overlay #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration write port
    input  wire logic                        i_cfg_we,
    input  wire logic [glo_pkg::IDX_W-1:0]   i_cfg_idx,
    input  wire logic [glo_pkg::CFG_W-1:0]   i_cfg_data,
    // pixel in
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [glo_pkg::PIX_W-1:0]   s_axis_tdata,   // red_in, green_in, blue_in
    // pixel out
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [glo_pkg::PIX_W-1:0]        m_axis_tdata,   // red_out, green_out, blue_out
    output logic                             m_axis_tuser,   // on_grid
    output logic                             m_axis_tlast    // frame_end
);

    localparam int DW  = $clog2(MAX_DIM + 1);
    localparam int CW  = $clog2(MAX_DIM);
    localparam int AW  = ((DW > glo_pkg::DIM_W) ? DW : glo_pkg::DIM_W) + 1;
    localparam int DCW = $clog2(DW + 1);
    localparam int PW  = glo_pkg::PARTS_W;

    // configuration registers
    logic [PW-1:0]                  r_column_parts, r_row_parts;
    logic [glo_pkg::THICK_W-1:0]    r_line_thickness;
    logic [glo_pkg::COLOR_W-1:0]    r_line_red, r_line_green, r_line_blue;
    logic [glo_pkg::DIM_W-1:0]      r_image_width, r_image_height;

    // sequencer and dividers
    glo_pkg::t_state                r_state, n_state;
    logic [DCW-1:0]                 r_div_cnt, n_div_cnt;
    logic [DW-1:0]                  r_q_c, n_q_c, r_q_r, n_q_r;
    logic [PW-1:0]                  r_rem_c, n_rem_c, r_rem_r, n_rem_r;

    // position counters and line walkers
    logic [CW-1:0]                  r_x, n_x, r_y, n_y;
    logic [PW-1:0]                  r_k_c, n_k_c, r_k_r, n_k_r;
    logic [AW-1:0]                  r_pos_c, n_pos_c, r_pos_r, n_pos_r;

    // output register
    logic                           r_m_valid, n_m_valid;
    logic [glo_pkg::PIX_W-1:0]      r_m_data;
    logic                           r_m_grid, r_m_last;

    logic [AW-1:0]                  w_ext, h_ext, w_eff, h_eff;
    logic [AW-1:0]                  x_ext, y_ext, half_ext, sp_c, sp_r;
    logic [AW-1:0]                  reach_c, reach_r;
    logic [PW:0]                    rs_c, rs_r;
    logic                           ge_c, ge_r;
    logic                           row_last, frame_last;
    logic                           left_c, left_r, c_on, r_on, grid;
    logic                           seek_c, seek_r, pass_c, pass_r;
    logic                           accept;

    // effective frame size: zero acts as one, clamp at MAX_DIM
    assign w_ext = AW'(r_image_width);
    assign h_ext = AW'(r_image_height);
    assign w_eff = (w_ext == '0) ? AW'(1) : ((w_ext > AW'(MAX_DIM)) ? AW'(MAX_DIM) : w_ext);
    assign h_eff = (h_ext == '0) ? AW'(1) : ((h_ext > AW'(MAX_DIM)) ? AW'(MAX_DIM) : h_ext);

    assign x_ext    = AW'(r_x);
    assign y_ext    = AW'(r_y);
    assign half_ext = AW'(r_line_thickness[glo_pkg::THICK_W-1:1]);
    assign sp_c     = AW'(r_q_c);
    assign sp_r     = AW'(r_q_r);
    assign reach_c  = r_pos_c + half_ext;
    assign reach_r  = r_pos_r + half_ext;

    assign row_last   = (x_ext + AW'(1)) >= w_eff;
    assign frame_last = row_last && ((y_ext + AW'(1)) >= h_eff);

    // restoring division steps
    assign rs_c = {r_rem_c, r_q_c[DW-1]};
    assign rs_r = {r_rem_r, r_q_r[DW-1]};
    assign ge_c = rs_c >= {1'b0, r_column_parts};
    assign ge_r = rs_r >= {1'b0, r_row_parts};

    // walker holds the first line whose band has not been passed yet
    assign left_c = r_k_c < r_column_parts;
    assign left_r = r_k_r < r_row_parts;
    assign c_on = (r_column_parts >= PW'(2)) &&
                  ((sp_c == '0) ? (x_ext <= half_ext)
                                : (left_c && (x_ext + half_ext >= r_pos_c)));
    assign r_on = (r_row_parts >= PW'(2)) &&
                  ((sp_r == '0) ? (y_ext <= half_ext)
                                : (left_r && (y_ext + half_ext >= r_pos_r)));
    assign grid = c_on || r_on;

    assign seek_c = left_c && (reach_c < x_ext);
    assign seek_r = left_r && (reach_r < y_ext);
    assign pass_c = left_c && (reach_c == x_ext);
    assign pass_r = left_r && (reach_r == y_ext);

    assign s_axis_tready = (r_state == glo_pkg::S_RUN) && (!r_m_valid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        n_q_c     = r_q_c;
        n_q_r     = r_q_r;
        n_rem_c   = r_rem_c;
        n_rem_r   = r_rem_r;
        n_x       = r_x;
        n_y       = r_y;
        n_k_c     = r_k_c;
        n_k_r     = r_k_r;
        n_pos_c   = r_pos_c;
        n_pos_r   = r_pos_r;
        n_m_valid = r_m_valid;

        case (r_state)
            glo_pkg::S_LOAD: begin
                n_q_c     = w_eff[DW-1:0];
                n_q_r     = h_eff[DW-1:0];
                n_rem_c   = '0;
                n_rem_r   = '0;
                n_div_cnt = '0;
                n_state   = glo_pkg::S_DIV;
            end
            glo_pkg::S_DIV: begin
                n_q_c     = {r_q_c[DW-2:0], ge_c};
                n_q_r     = {r_q_r[DW-2:0], ge_r};
                n_rem_c   = ge_c ? PW'(rs_c - {1'b0, r_column_parts}) : rs_c[PW-1:0];
                n_rem_r   = ge_r ? PW'(rs_r - {1'b0, r_row_parts}) : rs_r[PW-1:0];
                n_div_cnt = r_div_cnt + DCW'(1);
                if (r_div_cnt == DCW'(DW - 1)) begin
                    n_k_c   = PW'(1);
                    n_k_r   = PW'(1);
                    n_pos_c = AW'(n_q_c);
                    n_pos_r = AW'(n_q_r);
                    n_state = glo_pkg::S_SEEK;
                end
            end
            glo_pkg::S_SEEK: begin
                if (seek_c) begin
                    n_k_c   = r_k_c + PW'(1);
                    n_pos_c = r_pos_c + sp_c;
                end
                if (seek_r) begin
                    n_k_r   = r_k_r + PW'(1);
                    n_pos_r = r_pos_r + sp_r;
                end
                if (!seek_c && !seek_r) begin
                    n_state = glo_pkg::S_RUN;
                end
            end
            glo_pkg::S_RUN: begin
                if (accept) begin
                    if (row_last) begin
                        n_x     = '0;
                        n_k_c   = PW'(1);
                        n_pos_c = sp_c;
                        if (frame_last) begin
                            n_y     = '0;
                            n_k_r   = PW'(1);
                            n_pos_r = sp_r;
                        end else begin
                            n_y = r_y + CW'(1);
                            if (pass_r) begin
                                n_k_r   = r_k_r + PW'(1);
                                n_pos_r = r_pos_r + sp_r;
                            end
                        end
                    end else begin
                        n_x = r_x + CW'(1);
                        if (pass_c) begin
                            n_k_c   = r_k_c + PW'(1);
                            n_pos_c = r_pos_c + sp_c;
                        end
                    end
                end
            end
            default: begin
                n_state = glo_pkg::S_LOAD;
            end
        endcase

        if (accept) begin
            n_m_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        // any register write rebuilds the spacings
        if (i_cfg_we) begin
            n_state = glo_pkg::S_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= glo_pkg::S_LOAD;
            r_div_cnt        <= '0;
            r_x              <= '0;
            r_y              <= '0;
            r_k_c            <= PW'(1);
            r_k_r            <= PW'(1);
            r_pos_c          <= '0;
            r_pos_r          <= '0;
            r_m_valid        <= 1'b0;
            r_column_parts   <= PW'(1);
            r_row_parts      <= PW'(1);
            r_line_thickness <= glo_pkg::THICK_W'(1);
            r_line_red       <= '0;
            r_line_green     <= '0;
            r_line_blue      <= '0;
            r_image_width    <= glo_pkg::DIM_W'(640);
            r_image_height   <= glo_pkg::DIM_W'(480);
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
            r_x       <= n_x;
            r_y       <= n_y;
            r_k_c     <= n_k_c;
            r_k_r     <= n_k_r;
            r_pos_c   <= n_pos_c;
            r_pos_r   <= n_pos_r;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    glo_pkg::REG_COLUMN_PARTS:
                        r_column_parts   <= i_cfg_data[PW-1:0];
                    glo_pkg::REG_ROW_PARTS:
                        r_row_parts      <= i_cfg_data[PW-1:0];
                    glo_pkg::REG_LINE_THICKNESS:
                        r_line_thickness <= i_cfg_data[glo_pkg::THICK_W-1:0];
                    glo_pkg::REG_LINE_RED:
                        r_line_red       <= i_cfg_data[glo_pkg::COLOR_W-1:0];
                    glo_pkg::REG_LINE_GREEN:
                        r_line_green     <= i_cfg_data[glo_pkg::COLOR_W-1:0];
                    glo_pkg::REG_LINE_BLUE:
                        r_line_blue      <= i_cfg_data[glo_pkg::COLOR_W-1:0];
                    glo_pkg::REG_IMAGE_WIDTH:
                        r_image_width    <= i_cfg_data[glo_pkg::DIM_W-1:0];
                    glo_pkg::REG_IMAGE_HEIGHT:
                        r_image_height   <= i_cfg_data[glo_pkg::DIM_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // divider datapath and output payload
    always_ff @(posedge i_clk) begin
        r_q_c   <= n_q_c;
        r_q_r   <= n_q_r;
        r_rem_c <= n_rem_c;
        r_rem_r <= n_rem_r;
        if (accept) begin
            r_m_data <= grid ? {r_line_blue, r_line_green, r_line_red} : s_axis_tdata;
            r_m_grid <= grid;
            r_m_last <= frame_last;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_grid;
    assign m_axis_tlast  = r_m_last;

endmodule

`default_nettype wire

FILE: rtl/glo_checker.sv
// ----------------------------------------------------------------------------
// glo_checker
// port-level checks of the grid line overlay, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "grid_line_overlay_defines.svh"

module glo_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        s_axis_tvalid,
    input  wire logic                        s_axis_tready,
    input  wire logic                        m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    input  wire logic [glo_pkg::PIX_W-1:0]   m_axis_tdata,
    input  wire logic                        m_axis_tuser,
    input  wire logic                        m_axis_tlast
);

    // a stalled output pixel holds
    `GLO_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output pixel changed")

    // spacings are rebuilt after a register write, so input stalls
    `GLO_ASSERT_NEXT(a_cfg_stall, i_clk, i_rst_n, i_cfg_we, !s_axis_tready, "input ready right after a configuration write")

    // rebuild after reset as well
    `GLO_ASSERT_NEXT_ALWAYS(a_rst_stall, i_clk, !i_rst_n, !s_axis_tready, "input ready right after reset")

    // a newly raised output valid comes from an accepted input pixel
    `GLO_ASSERT_NOW(a_out_source, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready), "output pixel without input pixel")

endmodule

bind grid_line_overlay glo_checker u_glo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_we      (i_cfg_we),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

FILE: tb/sv/grid_line_overlay_test.sv
// ----------------------------------------------------------------------------
// grid_line_overlay_test
// self-checking bench for the grid line overlay
// ----------------------------------------------------------------------------
// Streams rgb pixels into the block and tracks the raster position, the
// spacings and the line bands in a local model. Every output pixel is
// compared with the oldest predicted one. Directed frames come first: reset
// defaults, a counter left beyond a shrunk width, a small grid, out-of-range
// dimensions and zero spacing. Then come a long output stall, a drained pause
// and random frame setups with random idling on both sides.
// ----------------------------------------------------------------------------

module grid_line_overlay_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_REGS     = 8;
    localparam int RANDOM_ITEMS = 640;
    localparam int LONG_HOLD    = 200;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct packed {
        bit [glo_pkg::COLOR_W-1:0] red;
        bit [glo_pkg::COLOR_W-1:0] green;
        bit [glo_pkg::COLOR_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        bit [glo_pkg::COLOR_W-1:0] red;
        bit [glo_pkg::COLOR_W-1:0] green;
        bit [glo_pkg::COLOR_W-1:0] blue;
        bit                        on_grid;
        bit                        frame_end;
    } t_overlay;

    typedef struct packed {
        bit [glo_pkg::PARTS_W-1:0] column_parts;
        bit [glo_pkg::PARTS_W-1:0] row_parts;
        bit [glo_pkg::THICK_W-1:0] thickness;
        bit [glo_pkg::COLOR_W-1:0] red;
        bit [glo_pkg::COLOR_W-1:0] green;
        bit [glo_pkg::COLOR_W-1:0] blue;
        bit [glo_pkg::DIM_W-1:0]   width;
        bit [glo_pkg::DIM_W-1:0]   height;
    } t_grid_cfg;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [glo_pkg::IDX_W-1:0]   i_cfg_idx;
    logic [glo_pkg::CFG_W-1:0]   i_cfg_data;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [glo_pkg::PIX_W-1:0]   s_axis_tdata;   // red_in, green_in, blue_in
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [glo_pkg::PIX_W-1:0]   m_axis_tdata;   // red_out, green_out, blue_out
    logic                        m_axis_tuser;   // on_grid
    logic                        m_axis_tlast;   // frame_end

    // local copy of the block's configuration and raster position
    t_grid_cfg  cfg_now;
    int         col_pos;
    int         row_pos;

    t_overlay   awaited_pixels[$];
    t_overlay   want_px;
    int         mismatches;
    int         items_sent;
    int         cycle_count;

    bit         in_gaps_on;
    bit         out_gaps_on;
    bit         hold_request;
    int         out_stall;

    grid_line_overlay uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------
    function automatic int eff_dim(input int v);
        if (v == 0) return 1;
        if (v > 4096) return 4096;
        return v;
    endfunction

    function automatic bit near_line(input int x, input int parts, input int spacing);
        int half;
        int pos;
        int delta;
        half = int'(cfg_now.thickness) / 2;
        for (int i = 1; i < parts; i++) begin
            pos   = i * spacing;
            delta = (x >= pos) ? x - pos : pos - x;
            if (delta <= half) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_overlay overlay_pixel(input t_pixel pix);
        t_overlay res;
        int w;
        int h;
        int cp;
        int rp;
        bit row_last;
        bit frame_last;
        bit grid;
        w  = eff_dim(int'(cfg_now.width));
        h  = eff_dim(int'(cfg_now.height));
        cp = int'(cfg_now.column_parts);
        rp = int'(cfg_now.row_parts);
        row_last   = (col_pos + 1 >= w);
        frame_last = row_last && (row_pos + 1 >= h);
        grid = near_line(row_pos, rp, (rp != 0) ? h / rp : 0)
            || near_line(col_pos, cp, (cp != 0) ? w / cp : 0);
        if (grid) begin
            res.red   = cfg_now.red;
            res.green = cfg_now.green;
            res.blue  = cfg_now.blue;
        end else begin
            res.red   = pix.red;
            res.green = pix.green;
            res.blue  = pix.blue;
        end
        res.on_grid   = grid;
        res.frame_end = frame_last;
        if (row_last) begin
            col_pos = 0;
            row_pos = frame_last ? 0 : row_pos + 1;
        end else begin
            col_pos++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // output side: random stalls, long hold on request, result check
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? int'($urandom_range(10, 40))
                                           : int'($urandom_range(1, 3));
    endfunction

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            out_stall = LONG_HOLD;
        end
        if (out_stall > 0) begin
            out_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (out_gaps_on && $urandom_range(0, 3) == 0) out_stall = pick_gap();
        end
    end

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (awaited_pixels.size() == 0) begin
                $display("%0t: unexpected pixel, expected none actual %h", $time,
                         {m_axis_tuser, m_axis_tlast, m_axis_tdata});
                mismatches++;
            end else begin
                want_px = awaited_pixels.pop_front();
                check_field("red", int'(want_px.red), int'(m_axis_tdata[7:0]));
                check_field("green", int'(want_px.green), int'(m_axis_tdata[15:8]));
                check_field("blue", int'(want_px.blue), int'(m_axis_tdata[23:16]));
                check_field("on_grid", int'(want_px.on_grid), int'(m_axis_tuser));
                check_field("frame_end", int'(want_px.frame_end), int'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    task automatic send_pixel(input t_pixel pix);
        int gap;
        gap = (in_gaps_on && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pix.blue, pix.green, pix.red};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        awaited_pixels.push_back(overlay_pixel(pix));
        items_sent++;
    endtask

    function automatic t_pixel random_pixel();
        t_pixel pix;
        pix.red   = glo_pkg::COLOR_W'($urandom_range(0, 255));
        pix.green = glo_pkg::COLOR_W'($urandom_range(0, 255));
        pix.blue  = glo_pkg::COLOR_W'($urandom_range(0, 255));
        return pix;
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (awaited_pixels.size() != 0) @(posedge i_clk);
    endtask

    // writes the registers selected by mask, once the block has gone quiet
    task automatic configure(input t_grid_cfg c, input bit [NUM_REGS-1:0] mask);
        logic [glo_pkg::IDX_W-1:0] idx;
        logic [glo_pkg::CFG_W-1:0] data;
        wait_for_results();
        for (int i = 0; i < NUM_REGS; i++) begin
            idx  = i[glo_pkg::IDX_W-1:0];
            data = '0;
            if (mask[i]) begin
                case (idx)
                    glo_pkg::REG_COLUMN_PARTS: begin
                        data = glo_pkg::CFG_W'(c.column_parts);
                        cfg_now.column_parts = c.column_parts;
                    end
                    glo_pkg::REG_ROW_PARTS: begin
                        data = glo_pkg::CFG_W'(c.row_parts);
                        cfg_now.row_parts = c.row_parts;
                    end
                    glo_pkg::REG_LINE_THICKNESS: begin
                        data = glo_pkg::CFG_W'(c.thickness);
                        cfg_now.thickness = c.thickness;
                    end
                    glo_pkg::REG_LINE_RED: begin
                        data = glo_pkg::CFG_W'(c.red);
                        cfg_now.red = c.red;
                    end
                    glo_pkg::REG_LINE_GREEN: begin
                        data = glo_pkg::CFG_W'(c.green);
                        cfg_now.green = c.green;
                    end
                    glo_pkg::REG_LINE_BLUE: begin
                        data = glo_pkg::CFG_W'(c.blue);
                        cfg_now.blue = c.blue;
                    end
                    glo_pkg::REG_IMAGE_WIDTH: begin
                        data = glo_pkg::CFG_W'(c.width);
                        cfg_now.width = c.width;
                    end
                    glo_pkg::REG_IMAGE_HEIGHT: begin
                        data = glo_pkg::CFG_W'(c.height);
                        cfg_now.height = c.height;
                    end
                    default: begin
                    end
                endcase
                @(negedge i_clk);
                i_cfg_we   <= 1'b1;
                i_cfg_idx  <= idx;
                i_cfg_data <= data;
                @(posedge i_clk);
            end
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_grid_cfg make_cfg(input int cp, input int rp, input int th,
                                           input int r, input int g, input int b,
                                           input int w, input int h);
        t_grid_cfg c;
        c.column_parts = glo_pkg::PARTS_W'(cp);
        c.row_parts    = glo_pkg::PARTS_W'(rp);
        c.thickness    = glo_pkg::THICK_W'(th);
        c.red          = glo_pkg::COLOR_W'(r);
        c.green        = glo_pkg::COLOR_W'(g);
        c.blue         = glo_pkg::COLOR_W'(b);
        c.width        = glo_pkg::DIM_W'(w);
        c.height       = glo_pkg::DIM_W'(h);
        return c;
    endfunction

    task automatic set_idling(input bit in_on, input bit out_on);
        in_gaps_on  = in_on;
        out_gaps_on = out_on;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_state();
        t_pixel pix;
        set_idling(1'b0, 1'b0);
        pix = '0;
        send_pixel(pix);
        pix = '1;
        send_pixel(pix);
        pix.red   = 8'hA5;
        pix.green = 8'h5A;
        pix.blue  = 8'h3C;
        send_pixel(pix);
    endtask

    // column counter already past the new width
    task automatic test_shrunk_counter();
        configure(make_cfg(1, 1, 1, 0, 0, 0, 2, 480), 8'h40);
        send_random(1);
    endtask

    task automatic test_small_grid();
        configure(make_cfg(2, 3, 0, 8'hFF, 8'h00, 8'h80, 4, 3), 8'hFF);
        send_random(12);
    endtask

    task automatic test_dimension_limits();
        // zero size behaves as a single pixel frame
        configure(make_cfg(0, 0, 1, 8'h00, 8'hFF, 8'h00, 0, 0), 8'hFF);
        send_random(2);
        // thick bands cover the whole oversized frame
        configure(make_cfg(31, 31, 8191, 8'h12, 8'h34, 8'h56, 8191, 4096), 8'hFF);
        send_random(2);
        configure(make_cfg(31, 31, 0, 8'h12, 8'h34, 8'h56, 4096, 4096), 8'h07);
        send_random(1);
    endtask

    // more parts than pixels puts every line at zero
    task automatic test_zero_spacing();
        configure(make_cfg(31, 0, 2, 8'hC3, 8'h3C, 8'h99, 3, 2), 8'hFF);
        send_random(6);
    endtask

    task automatic test_backpressure();
        configure(make_cfg(2, 2, 0, 8'h10, 8'h20, 8'h30, 5, 4), 8'hFF);
        set_idling(1'b0, 1'b0);
        @(posedge i_clk);
        hold_request = 1'b1;
        send_random(40);
    endtask

    task automatic test_drain_pause();
        set_idling(1'b1, 1'b1);
        send_random(10);
        wait_for_results();
        send_random(10);
    endtask

    function automatic int pick_parts();
        return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 31))
                                           : int'($urandom_range(0, 6));
    endfunction

    function automatic int pick_thickness();
        return ($urandom_range(0, 7) == 0) ? int'($urandom_range(0, 8191))
                                           : int'($urandom_range(0, 6));
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return int'($urandom_range(4097, 8191));
            2:       return 4096;
            3:       return int'($urandom_range(13, 300));
            default: return int'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic test_random_frames();
        t_grid_cfg c;
        bit [NUM_REGS-1:0] mask;
        int first_item;
        first_item = items_sent;
        mask = '1;
        while (items_sent - first_item < RANDOM_ITEMS) begin
            c = make_cfg(pick_parts(), pick_parts(), pick_thickness(),
                         int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
                         int'($urandom_range(0, 255)), pick_dim(), pick_dim());
            configure(c, mask);
            set_idling(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            send_random(int'($urandom_range(20, 60)));
            mask = ($urandom_range(0, 2) == 0) ? '1 : NUM_REGS'($urandom_range(1, 255));
        end
    endtask

    initial begin
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_now       = make_cfg(1, 1, 1, 0, 0, 0, 640, 480);
        col_pos       = 0;
        row_pos       = 0;
        mismatches    = 0;
        items_sent    = 0;
        cycle_count   = 0;
        in_gaps_on    = 1'b0;
        out_gaps_on   = 1'b0;
        hold_request  = 1'b0;
        out_stall     = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_shrunk_counter();
        test_small_grid();
        test_dimension_limits();
        test_zero_spacing();
        test_backpressure();
        test_drain_pause();
        test_random_frames();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/glo_pkg.sv
rtl/grid_line_overlay.sv
rtl/glo_checker.sv
tb/sv/grid_line_overlay_test.sv
